>>> hdl/pa_pkg.sv
// shared types and constants for the positional audio attenuation and pan block
package pa_pkg;

  typedef enum logic [2:0] {
    REG_SOUND_X   = 3'd0,
    REG_SOUND_Y   = 3'd1,
    REG_SOUND_Z   = 3'd2,
    REG_NEAR      = 3'd3,
    REG_FAR       = 3'd4,
    REG_BASE_VOL  = 3'd5,
    REG_FALLOFF   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic pan_ok;    // both horizontal directions have nonzero length
    logic sharp_one; // limit at full width
    logic in_near;   // distance at or inside near
    logic past_far;  // distance at or beyond far
  } pa_flags_t;

  localparam int DIV_QW      = 16;
  localparam int EXP_TERMS   = 12;
  localparam int EXP_SQUARES = 4;
  localparam int EXP_LAT     = 3 * EXP_TERMS + EXP_SQUARES + 1;

  localparam logic [15:0] ONE_Q15   = 16'd32768;
  localparam logic [15:0] PAN_FLOOR = 16'd11469;
  localparam logic [15:0] PAN_SPAN  = 16'd21299;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  localparam logic [23:0] NEAR_RESET    = 24'd1280;
  localparam logic [23:0] FAR_RESET     = 24'd5120;
  localparam logic [15:0] BASE_VOL_RESET = 16'd32768;
  localparam logic [15:0] FALLOFF_RESET = 16'd4096;

endpackage

>>> hdl/pa_dly.sv
// enabled shift-register delay line for words riding beside the arithmetic
module pa_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

>>> hdl/pa_sqrt.sv
// pipelined integer square root, one result bit per stage
module pa_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int SQW = 2 * RW;

  logic [SQW-1:0] rem_q [RW];
  logic [RW-1:0]  rt_q  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int B = RW - 1 - j;
    logic [SQW-1:0] rem_in;
    logic [RW-1:0]  rt_in;
    logic [SQW:0]   trial;
    logic           take;

    if (j == 0) begin : g_first
      assign rem_in = rad;
      assign rt_in  = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign rt_in  = rt_q[j-1];
    end

    // (2r + 2^b) * 2^b, the growth of the square when bit b is set
    assign trial = ((SQW+1)'(rt_in) << (B + 1)) | ((SQW+1)'(1) << (2 * B));
    assign take  = (SQW+1)'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rt_q[j] <= take ? (rt_in | (RW'(1) << B)) : rt_in;
      end
    end

    if (j < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= take ? (rem_in - trial[SQW-1:0]) : rem_in;
        end
      end
    end else begin : g_no_rem
      assign rem_q[j] = '0;
    end
  end

  assign root = rt_q[RW-1];

endmodule

>>> hdl/pa_div.sv
// pipelined restoring divider, one quotient bit per stage
module pa_div #(
  parameter int NW = 48,
  parameter int DW = 33,
  parameter int QW = pa_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int I = QW - 1 - j;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [XW-1:0] dsh;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign dsh  = XW'(den_in) << I;
    assign take = XW'(rem_in) >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[j] <= take ? (quo_in | (QW'(1) << I)) : quo_in;
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[j] <= take ? (rem_in - dsh[NW-1:0]) : rem_in;
          den_q[j] <= den_in;
        end
      end
    end else begin : g_last
      assign rem_q[j] = '0;
      assign den_q[j] = '0;
    end
  end

  assign quo = quo_q[QW-1];

endmodule

>>> hdl/pa_exp.sv
// pipelined exp(-x/4096) in q1.15: taylor series then four squarings
module pa_exp (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] x,
  output logic [15:0] e
);

  localparam int NT = pa_pkg::EXP_TERMS;
  localparam int NS = pa_pkg::EXP_SQUARES;

  logic [46:0] pa [NT];
  logic [30:0] ra [NT];
  logic [15:0] ya [NT];
  logic [30:0] ab [NT];
  logic [30:0] qb [NT];
  logic [30:0] rb [NT];
  logic [15:0] yb [NT];
  logic [30:0] tc [NT];
  logic [30:0] rc [NT];
  logic [15:0] yc [NT];
  logic [30:0] sq [NS];

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam int K = i + 1;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);
    logic [30:0] t_in;
    logic [30:0] r_in;
    logic [15:0] y_in;
    logic [63:0] qprod;
    logic [30:0] qk;
    logic [30:0] rem;
    logic [30:0] q;

    if (i == 0) begin : g_first
      assign t_in = pa_pkg::ONE_Q30;
      assign r_in = pa_pkg::ONE_Q30;
      assign y_in = x;
    end else begin : g_next
      assign t_in = tc[i-1];
      assign r_in = rc[i-1];
      assign y_in = yc[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pa[i] <= 47'(t_in) * 47'(y_in);
        ra[i] <= r_in;
        ya[i] <= y_in;
      end
    end

    // reciprocal estimate is low by at most one
    assign qprod = 64'(pa[i][46:16]) * 64'(RECIP);

    always_ff @(posedge clk) begin
      if (en) begin
        ab[i] <= pa[i][46:16];
        qb[i] <= qprod[62:32];
        rb[i] <= ra[i];
        yb[i] <= ya[i];
      end
    end

    assign qk  = 31'(qb[i] * 31'(K));
    assign rem = ab[i] - qk;
    assign q   = (rem >= 31'(K)) ? (qb[i] + 31'd1) : qb[i];

    always_ff @(posedge clk) begin
      if (en) begin
        tc[i] <= q;
        yc[i] <= yb[i];
      end
    end

    if (K % 2 == 1) begin : g_sub
      always_ff @(posedge clk) begin
        if (en) begin
          rc[i] <= rb[i] - q;
        end
      end
    end else begin : g_add
      always_ff @(posedge clk) begin
        if (en) begin
          rc[i] <= rb[i] + q;
        end
      end
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_square
    logic [30:0] s_in;
    logic [61:0] pr;

    if (j == 0) begin : g_first
      assign s_in = rc[NT-1];
    end else begin : g_next
      assign s_in = sq[j-1];
    end

    assign pr = 62'(s_in) * 62'(s_in) + 62'(pa_pkg::ONE_Q30 >> 1);

    always_ff @(posedge clk) begin
      if (en) begin
        sq[j] <= pr[60:30];
      end
    end
  end

  logic [30:0] fr;
  assign fr = sq[NS-1] + 31'd16384;

  always_ff @(posedge clk) begin
    if (en) begin
      e <= fr[30:15];
    end
  end

endmodule

>>> hdl/positional_audio_attenuation_pan.sv
// Throughput: one word per cycle; the pipeline stalls as a whole only while a finished
// word waits at the output, and an empty input stage still takes a word then.
// Depth is set by the square roots (one bit per stage), the 16-stage dividers and the
// 12-term exponential series at three stages per term.
// Reset clears every valid bit and loads the configuration registers with their defaults.
module positional_audio_attenuation_pan #(
  parameter int COORD_WIDTH = 32,
  localparam int CFGW = (COORD_WIDTH > 24) ? COORD_WIDTH : 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [2:0]                    cfg_index,
  input  logic [CFGW-1:0]               cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] cam_x,
  input  logic signed [COORD_WIDTH-1:0] cam_y,
  input  logic signed [COORD_WIDTH-1:0] cam_z,
  input  logic signed [COORD_WIDTH-1:0] look_x,
  input  logic signed [COORD_WIDTH-1:0] look_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            pan,
  output logic [15:0]                   gain
);

  localparam int CW    = COORD_WIDTH;
  localparam int MW    = CW + 1;
  localparam int SQW   = 2 * MW;
  localparam int RW    = MW;
  localparam int UNW   = MW + 15;
  localparam int DCW   = (RW > 25) ? RW : 25;
  localparam int LVL_A = 4 + RW;
  localparam int LVL_B = LVL_A + 1 + pa_pkg::DIV_QW;
  localparam int LAT   = LVL_B + pa_pkg::EXP_LAT + 2;

  // configuration
  logic signed [CW-1:0] sound_x, sound_y, sound_z;
  logic [23:0] near_distance, far_distance;
  logic [15:0] base_volume, falloff_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_x       <= '0;
      sound_y       <= '0;
      sound_z       <= '0;
      near_distance <= pa_pkg::NEAR_RESET;
      far_distance  <= pa_pkg::FAR_RESET;
      base_volume   <= pa_pkg::BASE_VOL_RESET;
      falloff_rate  <= pa_pkg::FALLOFF_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pa_pkg::REG_SOUND_X:  sound_x       <= cfg_data[CW-1:0];
        pa_pkg::REG_SOUND_Y:  sound_y       <= cfg_data[CW-1:0];
        pa_pkg::REG_SOUND_Z:  sound_z       <= cfg_data[CW-1:0];
        pa_pkg::REG_NEAR:     near_distance <= cfg_data[23:0];
        pa_pkg::REG_FAR:      far_distance  <= cfg_data[23:0];
        pa_pkg::REG_BASE_VOL: base_volume   <= cfg_data[15:0];
        pa_pkg::REG_FALLOFF:  falloff_rate  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [LAT-1:0] vld;
  logic           adv;

  assign out_valid = vld[LAT-1];
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv || !vld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (in_ready) begin
        vld[0] <= in_valid;
      end
      if (adv) begin
        vld[LAT-1:1] <= vld[LAT-2:0];
      end
    end
  end

  // differences
  logic signed [CW:0] dx1, dy1, dz1, lx1, ly1;

  always_ff @(posedge clk) begin
    if (in_ready) begin
      dx1 <= {sound_x[CW-1], sound_x} - {cam_x[CW-1], cam_x};
      dy1 <= {sound_y[CW-1], sound_y} - {cam_y[CW-1], cam_y};
      dz1 <= {sound_z[CW-1], sound_z} - {cam_z[CW-1], cam_z};
      lx1 <= {look_x[CW-1], look_x} - {cam_x[CW-1], cam_x};
      ly1 <= {look_y[CW-1], look_y} - {cam_y[CW-1], cam_y};
    end
  end

  // magnitudes
  logic [MW-1:0] mdx2, mdy2, mdz2, mlx2, mly2;
  logic [3:0]    sg2;

  always_ff @(posedge clk) begin
    if (adv) begin
      mdx2 <= dx1[CW] ? $unsigned(-dx1) : $unsigned(dx1);
      mdy2 <= dy1[CW] ? $unsigned(-dy1) : $unsigned(dy1);
      mdz2 <= dz1[CW] ? $unsigned(-dz1) : $unsigned(dz1);
      mlx2 <= lx1[CW] ? $unsigned(-lx1) : $unsigned(lx1);
      mly2 <= ly1[CW] ? $unsigned(-ly1) : $unsigned(ly1);
      sg2  <= {lx1[CW], ly1[CW], dx1[CW], dy1[CW]};
    end
  end

  // squares
  logic [SQW-1:0] sqx3, sqy3, sqz3, sqlx3, sqly3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx3  <= SQW'(mdx2) * SQW'(mdx2);
      sqy3  <= SQW'(mdy2) * SQW'(mdy2);
      sqz3  <= SQW'(mdz2) * SQW'(mdz2);
      sqlx3 <= SQW'(mlx2) * SQW'(mlx2);
      sqly3 <= SQW'(mly2) * SQW'(mly2);
    end
  end

  // sums of squares
  logic [SQW-1:0] dsq4, hs4, hl4;

  always_ff @(posedge clk) begin
    if (adv) begin
      dsq4 <= sqx3 + sqy3 + sqz3;
      hs4  <= sqx3 + sqy3;
      hl4  <= sqlx3 + sqly3;
    end
  end

  logic [RW-1:0] dist_a, slen_a, llen_a;

  pa_sqrt #(.RW(RW)) u_sqrt_dist (.clk(clk), .en(adv), .rad(dsq4), .root(dist_a));
  pa_sqrt #(.RW(RW)) u_sqrt_snd  (.clk(clk), .en(adv), .rad(hs4),  .root(slen_a));
  pa_sqrt #(.RW(RW)) u_sqrt_look (.clk(clk), .en(adv), .rad(hl4),  .root(llen_a));

  logic [4*MW-1:0] mag_a;
  logic [3:0]      sg_b;

  pa_dly #(.WIDTH(4*MW), .DEPTH(RW+2)) u_dly_mag (
    .clk(clk), .en(adv), .d({mlx2, mly2, mdx2, mdy2}), .q(mag_a)
  );

  pa_dly #(.WIDTH(4), .DEPTH(LVL_B-2)) u_dly_sign (
    .clk(clk), .en(adv), .d(sg2), .q(sg_b)
  );

  // divider operands and range flags
  logic [DCW-1:0] dist_w, near_w, near2_w, far_w, diff_w;
  logic [23:0]    diff24;

  assign dist_w  = DCW'(dist_a);
  assign near_w  = DCW'(near_distance);
  assign near2_w = DCW'({near_distance, 1'b0});
  assign far_w   = DCW'(far_distance);
  assign diff_w  = dist_w - near_w;
  assign diff24  = diff_w[23:0];

  logic [UNW-1:0]    nlx_p, nly_p, ndx_p, ndy_p;
  logic [RW-1:0]     llen_p, slen_p;
  logic [38:0]       shn_p;
  logic [23:0]       near_p, exd_p;
  logic [39:0]       exn_p;
  pa_pkg::pa_flags_t fl_p, fl_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      nlx_p  <= {mag_a[4*MW-1:3*MW], 15'd0};
      nly_p  <= {mag_a[3*MW-1:2*MW], 15'd0};
      ndx_p  <= {mag_a[2*MW-1:MW], 15'd0};
      ndy_p  <= {mag_a[MW-1:0], 15'd0};
      llen_p <= llen_a;
      slen_p <= slen_a;
      shn_p  <= {diff24, 15'd0};
      near_p <= near_distance;
      exn_p  <= 40'(diff24) * 40'(falloff_rate);
      exd_p  <= far_distance - near_distance;
      fl_p.pan_ok    <= (llen_a != '0) && (slen_a != '0);
      fl_p.sharp_one <= (near_distance == '0) || (dist_w >= near2_w);
      fl_p.in_near   <= dist_w <= near_w;
      fl_p.past_far  <= dist_w >= far_w;
    end
  end

  logic [pa_pkg::DIV_QW-1:0] qlx, qly, qdx, qdy, qsh, qex;

  pa_div #(.NW(UNW), .DW(RW)) u_div_lx (
    .clk(clk), .en(adv), .num(nlx_p), .den(llen_p), .quo(qlx));
  pa_div #(.NW(UNW), .DW(RW)) u_div_ly (
    .clk(clk), .en(adv), .num(nly_p), .den(llen_p), .quo(qly));
  pa_div #(.NW(UNW), .DW(RW)) u_div_dx (
    .clk(clk), .en(adv), .num(ndx_p), .den(slen_p), .quo(qdx));
  pa_div #(.NW(UNW), .DW(RW)) u_div_dy (
    .clk(clk), .en(adv), .num(ndy_p), .den(slen_p), .quo(qdy));
  pa_div #(.NW(39), .DW(24)) u_div_sharp (
    .clk(clk), .en(adv), .num(shn_p), .den(near_p), .quo(qsh));
  pa_div #(.NW(40), .DW(24)) u_div_exp (
    .clk(clk), .en(adv), .num(exn_p), .den(exd_p), .quo(qex));

  pa_dly #(.WIDTH($bits(pa_pkg::pa_flags_t)), .DEPTH(pa_pkg::DIV_QW)) u_dly_flags (
    .clk(clk), .en(adv), .d(fl_p), .q(fl_b)
  );

  // pan: cross product of the unit vectors, then limit
  logic signed [16:0] ulx, uly, udx, udy;
  logic [15:0]        s_eff;
  logic [31:0]        span_prod;

  assign ulx = sg_b[3] ? -$signed({1'b0, qlx}) : $signed({1'b0, qlx});
  assign uly = sg_b[2] ? -$signed({1'b0, qly}) : $signed({1'b0, qly});
  assign udx = sg_b[1] ? -$signed({1'b0, qdx}) : $signed({1'b0, qdx});
  assign udy = sg_b[0] ? -$signed({1'b0, qdy}) : $signed({1'b0, qdy});

  assign s_eff = fl_b.sharp_one ? pa_pkg::ONE_Q15 :
                 fl_b.in_near   ? 16'd0 : qsh;
  assign span_prod = 32'(pa_pkg::PAN_SPAN) * 32'(s_eff);

  logic signed [33:0] p1_1, p2_1;
  logic [15:0]        lim_1, lim_2;
  logic               ok_1, ok_2;
  logic signed [34:0] c_2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_1  <= 34'(uly) * 34'(udx);
      p2_1  <= 34'(ulx) * 34'(udy);
      lim_1 <= pa_pkg::PAN_FLOOR + 16'(span_prod >> 15);
      ok_1  <= fl_b.pan_ok;
      c_2   <= 35'(p1_1) - 35'(p2_1);
      lim_2 <= lim_1;
      ok_2  <= ok_1;
    end
  end

  logic [34:0] cmag, rnd;
  logic [16:0] rm, rneg;
  logic [15:0] pan_v, pan_3, pan_q;

  assign cmag = c_2[34] ? $unsigned(-c_2) : $unsigned(c_2);
  assign rnd  = (cmag + 35'd16384) >> 15;
  assign rm   = (rnd > 35'(lim_2)) ? {1'b0, lim_2} : rnd[16:0];
  assign rneg = -rm;

  always_comb begin
    if (!ok_2) begin
      pan_v = '0;
    end else if (c_2[34]) begin
      pan_v = rneg[15:0];
    end else if (rm > 17'd32767) begin
      pan_v = 16'h7fff;
    end else begin
      pan_v = rm[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pan_3 <= pan_v;
    end
  end

  pa_dly #(.WIDTH(16), .DEPTH(pa_pkg::EXP_LAT-1)) u_dly_pan (
    .clk(clk), .en(adv), .d(pan_3), .q(pan_q)
  );

  assign pan = pan_q;

  // volume
  logic [15:0] e_exp, e_sel;
  logic [1:0]  fl_e;
  logic [31:0] gp;
  logic [32:0] gr;
  logic [15:0] gain_r;

  pa_exp u_exp (.clk(clk), .en(adv), .x(qex), .e(e_exp));

  pa_dly #(.WIDTH(2), .DEPTH(pa_pkg::EXP_LAT)) u_dly_range (
    .clk(clk), .en(adv), .d({fl_b.in_near, fl_b.past_far}), .q(fl_e)
  );

  assign e_sel = fl_e[1] ? pa_pkg::ONE_Q15 :
                 fl_e[0] ? 16'd0 : e_exp;
  assign gr    = (33'(gp) + 33'd16384) >> 15;

  always_ff @(posedge clk) begin
    if (adv) begin
      gp     <= 32'(e_sel) * 32'(base_volume);
      gain_r <= (gr > 33'd65535) ? 16'hffff : gr[15:0];
    end
  end

  assign gain = gain_r;

endmodule

>>> hdl/pa_chk.sv
// port-level checks for the positional audio block, bound to the top level
module pa_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pan,
  input logic [15:0] gain
);

  // reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  // input only backs up behind a blocked output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked output word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pan) && $stable(gain)))
    else $error("output word changed while stalled");

  // an offered word is always taken while no output word is pending
  a_accept_pipe: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_valid) |-> in_ready)
    else $error("pipeline refused a word with an empty output");

endmodule

bind positional_audio_attenuation_pan pa_chk u_pa_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pan(pan), .gain(gain)
);

>>> dv/pa_checker.sv
// checker for the positional audio block: predicts pan and gain and compares each output word
module pa_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int CFGW = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [2:0]                    cfg_index,
  input  logic [CFGW-1:0]               cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] cam_x,
  input  logic signed [COORD_WIDTH-1:0] cam_y,
  input  logic signed [COORD_WIDTH-1:0] cam_z,
  input  logic signed [COORD_WIDTH-1:0] look_x,
  input  logic signed [COORD_WIDTH-1:0] look_y,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [15:0]            pan,
  input  logic [15:0]                   gain,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic signed [15:0] pan;
    logic [15:0]        gain;
  } audio_word_t;

  localparam int QDEPTH = 1024;

  logic signed [COORD_WIDTH-1:0] src_x, src_y, src_z;
  logic [23:0] near_d, far_d;
  logic [15:0] base_vol, falloff;
  audio_word_t expected_words [QDEPTH];
  logic [9:0] wr_ptr, rd_ptr, fill;

  // floor square root of a nonnegative value up to 128 bits
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic longint unit_comp(input longint comp, input logic [63:0] len);
    logic [127:0] m;
    longint q;
    m = (comp < 0) ? 128'(-comp) : 128'(comp);
    q = longint'((m << 15) / len);
    return (comp < 0) ? -q : q;
  endfunction

  function automatic logic [63:0] neg_exp_q15(input logic [63:0] y);
    logic [63:0] r, t;
    r = 64'(pa_pkg::ONE_Q30);
    t = 64'(pa_pkg::ONE_Q30);
    for (int k = 1; k <= pa_pkg::EXP_TERMS; k++) begin
      t = ((t * y) >> 16) / k;
      if (k % 2 == 1) r = r - t;
      else r = r + t;
    end
    for (int i = 0; i < pa_pkg::EXP_SQUARES; i++) r = (r * r + (64'd1 << 29)) >> 30;
    return (r + (64'd1 << 14)) >> 15;
  endfunction

  function automatic audio_word_t predict_audio(input longint cx, input longint cy,
                                                input longint cz, input longint lkx,
                                                input longint lky);
    audio_word_t w;
    longint dx, dy, dz, lx, ly, c, r, lim_s, p;
    logic [127:0] sq;
    logic [63:0] d_len, sharp, lim, llen, slen, e, g, xexp;
    dx = longint'(src_x) - cx;
    dy = longint'(src_y) - cy;
    dz = longint'(src_z) - cz;
    lx = lkx - cx;
    ly = lky - cy;
    sq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
    d_len = floor_sqrt(sq);
    if (near_d == 0 || d_len >= 2 * 64'(near_d)) sharp = 64'(pa_pkg::ONE_Q15);
    else if (d_len <= near_d) sharp = 0;
    else sharp = ((d_len - near_d) << 15) / near_d;
    lim = 64'(pa_pkg::PAN_FLOOR) + ((64'(pa_pkg::PAN_SPAN) * sharp) >> 15);
    llen = floor_sqrt(128'(lx) * 128'(lx) + 128'(ly) * 128'(ly));
    slen = floor_sqrt(128'(dx) * 128'(dx) + 128'(dy) * 128'(dy));
    p = 0;
    if (llen != 0 && slen != 0) begin
      c = unit_comp(ly, llen) * unit_comp(dx, slen) - unit_comp(lx, llen) * unit_comp(dy, slen);
      r = ((c < 0 ? -c : c) + (64'd1 << 14)) >>> 15;
      p = (c < 0) ? -r : r;
      lim_s = longint'(lim);
      if (p > lim_s) p = lim_s;
      if (p < -lim_s) p = -lim_s;
      if (p > 32767) p = 32767;
    end
    if (d_len <= near_d) e = 64'(pa_pkg::ONE_Q15);
    else if (d_len >= far_d) e = 0;
    else begin
      xexp = ((d_len - near_d) * falloff) / (64'(far_d) - near_d);
      e = neg_exp_q15(xexp);
    end
    g = (e * base_vol + (64'd1 << 14)) >> 15;
    if (g > 65535) g = 65535;
    w.pan = p[15:0];
    w.gain = g[15:0];
    return w;
  endfunction

  always @(posedge clk) begin
    audio_word_t exp_w;
    int errs;
    errs = 0;
    if (rst) begin
      src_x <= '0; src_y <= '0; src_z <= '0;
      near_d <= pa_pkg::NEAR_RESET; far_d <= pa_pkg::FAR_RESET;
      base_vol <= pa_pkg::BASE_VOL_RESET; falloff <= pa_pkg::FALLOFF_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words[wr_ptr] <= predict_audio(cam_x, cam_y, cam_z, look_x, look_y);
        wr_ptr <= wr_ptr + 10'd1;
      end
      if (out_valid && out_ready) begin
        if (fill == 0) begin
          $error("unexpected output word pan=%0d gain=%0d", pan, gain);
          errs++;
        end else begin
          exp_w = expected_words[rd_ptr];
          rd_ptr <= rd_ptr + 10'd1;
          if (pan !== exp_w.pan) begin
            $error("pan: expected %0d actual %0d", exp_w.pan, pan);
            errs++;
          end
          if (gain !== exp_w.gain) begin
            $error("gain: expected %0d actual %0d", exp_w.gain, gain);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (cfg_wr_en) begin
        case (cfg_index)
          pa_pkg::REG_SOUND_X:  src_x <= cfg_data[COORD_WIDTH-1:0];
          pa_pkg::REG_SOUND_Y:  src_y <= cfg_data[COORD_WIDTH-1:0];
          pa_pkg::REG_SOUND_Z:  src_z <= cfg_data[COORD_WIDTH-1:0];
          pa_pkg::REG_NEAR:     near_d <= cfg_data[23:0];
          pa_pkg::REG_FAR:      far_d <= cfg_data[23:0];
          pa_pkg::REG_BASE_VOL: base_vol <= cfg_data[15:0];
          pa_pkg::REG_FALLOFF:  falloff <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  assign fill = wr_ptr - rd_ptr;
  assign pending = int'(fill);

endmodule

>>> dv/tb.sv
// top of the positional audio testbench: stimulus, configuration phases and verdict
module tb;

  localparam int CW = 32;
  localparam int CFGW = 32;
  localparam int LATENCY = CW + 65;
  localparam int N_RANDOM = 1630;
  localparam int WATCHDOG = 20000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic [2:0] cfg_index = '0;
  logic [CFGW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [CW-1:0] cam_x = '0, cam_y = '0, cam_z = '0, look_x = '0, look_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [15:0] pan;
  logic [15:0] gain;
  int fail_count, pending;
  int sent_words = 0, got_words = 0, idle_cycles = 0, setting_count = 0;
  bit calm = 0;        // no idling near the end
  bit hold_off = 0;    // long receiver stall requested

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  positional_audio_attenuation_pan #(.COORD_WIDTH(CW)) dut (.*);

  pa_checker #(.COORD_WIDTH(CW), .CFGW(CFGW)) checker_i (.*);

  // receiver with random stall bursts and one long hold-off
  initial begin
    int n;
    @(posedge clk);
    while (1) begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 9);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (out_valid && out_ready) got_words <= got_words + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no traffic, %0d words pending", pending);
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [CFGW-1:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic send_word(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                           input logic [CW-1:0] cz, input logic [CW-1:0] lx,
                           input logic [CW-1:0] ly);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      n = $urandom_range(1, 9);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1;
    cam_x <= cx; cam_y <= cy; cam_z <= cz; look_x <= lx; look_y <= ly;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
  endtask

  task automatic end_burst;
    in_valid <= 0;
    @(posedge clk);
  endtask

  // mostly small coordinates near the sound so distances land across near..far
  function automatic logic [CW-1:0] rand_coord(input logic [CW-1:0] center);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return {1'b0, {(CW-1){1'b1}}};
      default: return center + CW'($signed($urandom_range(0, 16000)) - 8000);
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [CW-1:0] c0, c1, c2;
    for (int i = 0; i < count; i++) begin
      c0 = rand_coord(checker_i.src_x);
      c1 = rand_coord(checker_i.src_y);
      c2 = rand_coord(checker_i.src_z);
      send_word(c0, c1, c2, rand_coord(c0), rand_coord(c1));
    end
    end_burst();
    drain();
  endtask

  task automatic new_setting(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                             input logic [CW-1:0] sz, input logic [23:0] nd,
                             input logic [23:0] fd, input logic [15:0] bv,
                             input logic [15:0] fr);
    write_reg(pa_pkg::REG_SOUND_X, sx);
    write_reg(pa_pkg::REG_SOUND_Y, sy);
    write_reg(pa_pkg::REG_SOUND_Z, sz);
    write_reg(pa_pkg::REG_NEAR, CFGW'(nd));
    write_reg(pa_pkg::REG_FAR, CFGW'(fd));
    write_reg(pa_pkg::REG_BASE_VOL, CFGW'(bv));
    write_reg(pa_pkg::REG_FALLOFF, CFGW'(fr));
    cfg_wr_en <= 0;
    setting_count++;
  endtask

  localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed words at reset settings
    send_word('0, '0, '0, '0, '0);                 // zero horizontal length both
    send_word(32'sd100, '0, '0, 32'sd100, 32'sd500); // look along +y, sound off to -x
    send_word(32'sd1000, '0, '0, 32'sd2000, '0);   // collinear
    send_word('0, 32'sd2000, '0, 32'sd500, 32'sd2000);  // full right side
    send_word('0, -32'sd2000, '0, 32'sd500, -32'sd2000);
    send_word(32'sd1280, '0, '0, 32'sd1280, 32'sd300);  // exactly near
    send_word(32'sd5120, '0, '0, 32'sd5120, 32'sd300);  // exactly far
    send_word(32'sd2000, '0, '0, 32'sd2000, 32'sd1);
    send_word(32'sd1500, 32'sd1500, 32'sd1000, '0, '0);
    send_word(CMAX, CMAX, CMAX, CMIN, CMIN);
    send_word(CMIN, CMIN, CMIN, CMAX, CMAX);
    send_word(CMAX, CMIN, CMAX, CMAX, CMIN);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
    end_burst();
    drain();

    // extreme registers: near zero, near above far, zero falloff, full volume
    new_setting(CMAX, CMIN, CMAX, 24'd0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
    send_word(CMIN, CMAX, CMIN, '0, '0);
    send_word(CMAX, CMIN, CMAX, CMAX, CMAX);
    send_word('0, '0, '0, 32'sd7, -32'sd9);
    end_burst();
    drain();
    new_setting('0, '0, '0, 24'hFFFFFF, 24'd0, 16'hFFFF, 16'd0);
    send_word(32'sd100, 32'sd100, '0, 32'sd200, '0);
    send_word(CMAX, '0, '0, '0, 32'sd5);
    end_burst();
    drain();
    new_setting('0, '0, '0, 24'd1000, 24'd9000, 16'hFFFF, 16'd0);
    random_phase(100);

    // long receiver stall while words keep coming
    new_setting(32'sd3000, -32'sd2000, 32'sd500, 24'd1280, 24'd5120, 16'd32768, 16'd4096);
    hold_off = 1;
    random_phase(300);

    new_setting(-32'sd7000, 32'sd4000, '0, 24'd256, 24'd12000, 16'd40000, 16'd20000);
    random_phase(300);
    new_setting($urandom, $urandom, $urandom, 24'd3000, 24'd3000, 16'd0, 16'd65535);
    random_phase(150);
    new_setting('0, 32'sd1, '0, 24'd1, 24'd16000, 16'd12345, 16'd1);
    random_phase(300);
    new_setting(32'sd500, 32'sd500, 32'sd500, 24'd2000, 24'd6000, 16'd32768, 16'd8192);
    random_phase(300);
    calm = 1;
    random_phase(N_RANDOM - 1450);
    write_reg(REG_UNUSED, '1);  // out-of-range index, ignored
    cfg_wr_en <= 0;
    random_phase(20);

    $display("tb: %0d words sent, %0d checked over %0d register settings",
             sent_words, got_words, setting_count);
    if (fail_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

>>> positional_audio_attenuation_pan.f
hdl/pa_pkg.sv
hdl/pa_dly.sv
hdl/pa_sqrt.sv
hdl/pa_div.sv
hdl/pa_exp.sv
hdl/positional_audio_attenuation_pan.sv
hdl/pa_chk.sv
dv/pa_checker.sv
dv/tb.sv
